/* rtl/core/swbt_pkg.sv */
package swbt_pkg;

	// Field widths fixed by the register and result formats
	localparam int unsigned CFG_W   = 9;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned STATE_W = 2;
	localparam int unsigned INDEX_W = 1;

	// Register indexes on the configuration port
	localparam logic [INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [INDEX_W-1:0] REG_SET_THRESHOLD = 1'b1;

	// Reset values of the registers
	localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 9'd256;
	localparam logic [CFG_W-1:0] SET_THRESHOLD_RST = 9'd128;

	typedef enum logic [STATE_W-1:0] {
		ST_NOT_FILLED = 2'd0,
		ST_BELOW      = 2'd1,
		ST_ABOVE      = 2'd2
	} win_state_t;

	// Fill status of the window around one request
	typedef struct packed {
		logic full_before;
		logic full_after;
	} win_flags_t;

endpackage

/* rtl/core/swbt_in_if.sv */
interface swbt_in_if;
	logic valid;
	logic ready;
	logic bit_in;

	modport source (output valid, output bit_in, input ready);
	modport sink (input valid, input bit_in, output ready);
endinterface

/* rtl/core/swbt_out_if.sv */
interface swbt_out_if;
	logic                           valid;
	logic                           ready;
	logic [swbt_pkg::STATE_W-1:0]   from_state;
	logic [swbt_pkg::STATE_W-1:0]   to_state;
	logic [swbt_pkg::COUNT_W-1:0]   ones_in_window;

	modport source (output valid, output from_state, output to_state, output ones_in_window,
		input ready);
	modport sink (input valid, input from_state, input to_state, input ones_in_window,
		output ready);
endinterface

/* rtl/core/sliding_window_bit_threshold.sv */
// Channel   Role    Payload
// in_ch     sink    bit_in
// out_ch    source  from_state, to_state, ones_in_window
// cfg       write   cfg_we, cfg_index, cfg_data (0 window_length, 1 set_threshold)
//
// One request per cycle while out_ch.ready holds; out_ch.valid rises as stage 1 advances.
// Accept cycle: ring read of the oldest bit and write of the new bit at one slot.
// Stage 1: count update and threshold compare, then the output register.
// Reset clears pointer, fill count, count, state and valid flags; the ring is not cleared.
// A stalled output holds stage 1, and in_ch.ready drops only when both are full.
module sliding_window_bit_threshold #(
	parameter int unsigned WINDOW_MAX = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	swbt_in_if.sink                        in_ch,
	swbt_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [swbt_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [swbt_pkg::CFG_W-1:0]     cfg_data
);

	localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	// Common width for comparing the 9-bit length against the window size
	localparam int unsigned LW = (AW + 1 > swbt_pkg::CFG_W) ? AW + 1 : swbt_pkg::CFG_W;
	localparam logic [LW-1:0] WMAX_L = LW'(WINDOW_MAX);

	// Configuration registers
	logic [swbt_pkg::CFG_W-1:0] wlen_q;
	logic [swbt_pkg::CFG_W-1:0] thr_q;
	logic                       restart;

	// Effective window length: zero reads as one, large values clip to the ring size
	logic [swbt_pkg::CFG_W-1:0] len;

	// Handshake
	logic accept;
	logic advance;
	logic s1_v_q;
	logic out_v_q;

	// Stage 1 payload
	logic                   bit_s1;
	logic                   old_bit_s1;
	swbt_pkg::win_flags_t   flags_s1;

	// Accept-cycle signals from the pointer tracker
	logic [AW-1:0]          ptr;
	swbt_pkg::win_flags_t   flags;

	// Stage 1 results
	swbt_pkg::win_state_t           from_state;
	swbt_pkg::win_state_t           to_state;
	logic [swbt_pkg::COUNT_W-1:0]   ones;

	// Output register
	logic [swbt_pkg::STATE_W-1:0]   from_q;
	logic [swbt_pkg::STATE_W-1:0]   to_q;
	logic [swbt_pkg::COUNT_W-1:0]   ones_q;

	always_comb begin
		if (wlen_q == '0)
			len = swbt_pkg::CFG_W'(1);
		else if (LW'(wlen_q) > WMAX_L)
			len = WMAX_L[swbt_pkg::CFG_W-1:0];
		else
			len = wlen_q;
	end

	// Only a window_length write restarts the window
	assign restart = cfg_we && (cfg_index == swbt_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= swbt_pkg::WINDOW_LENGTH_RST;
			thr_q  <= swbt_pkg::SET_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				swbt_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_data;
				swbt_pkg::REG_SET_THRESHOLD: thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the output register is empty or being drained
	assign advance     = s1_v_q && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !s1_v_q || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept)
				s1_v_q <= 1'b1;
			else if (advance)
				s1_v_q <= 1'b0;
			if (advance)
				out_v_q <= 1'b1;
			else if (out_ch.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1   <= in_ch.bit_in;
			flags_s1 <= flags;
		end
		if (advance) begin
			from_q <= from_state;
			to_q   <= to_state;
			ones_q <= ones;
		end
	end

	swbt_ctrl #(.AW(AW)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.restart (restart),
		.len     (len),
		.ptr     (ptr),
		.flags   (flags)
	);

	swbt_ring #(.DEPTH(WINDOW_MAX), .AW(AW)) u_ring (
		.clk      (clk),
		.en       (accept),
		.addr     (ptr),
		.wdata    (in_ch.bit_in),
		.rdata_s1 (old_bit_s1)
	);

	swbt_count u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.advance    (advance),
		.bit_s1     (bit_s1),
		.old_bit_s1 (old_bit_s1),
		.flags_s1   (flags_s1),
		.len        (len),
		.thr        (thr_q),
		.from_state (from_state),
		.to_state   (to_state),
		.ones       (ones)
	);

	assign out_ch.valid          = out_v_q;
	assign out_ch.from_state     = from_q;
	assign out_ch.to_state       = to_q;
	assign out_ch.ones_in_window = ones_q;

	// Count never exceeds the window length
	a_ones_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> ones <= len)
		else $error("set-bit count above window length");

	// Above means the count reached the threshold
	a_above_thr: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (to_state == swbt_pkg::ST_ABOVE) |-> ones >= thr_q)
		else $error("above state with count under threshold");

	// A filled window stays filled until restart
	a_stay_filled: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (from_state != swbt_pkg::ST_NOT_FILLED)
			|-> to_state != swbt_pkg::ST_NOT_FILLED)
		else $error("window dropped back to not filled");

	// A request in stage 1 is never overwritten before it moves on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !advance |-> !accept)
		else $error("stage 1 overwritten while held");

endmodule

/* rtl/core/swbt_ring.sv */
// Bit ring: one read and one write at the same slot per request.
// Read returns the bit held before this write.
module swbt_ring #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata_s1
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1   <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

endmodule

/* rtl/core/swbt_ctrl.sv */
// Write pointer and fill count, advanced at each accepted request.
module swbt_ctrl #(
	parameter int unsigned AW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          restart,
	input  logic [swbt_pkg::CFG_W-1:0]    len,
	output logic [AW-1:0]                 ptr,
	output swbt_pkg::win_flags_t          flags
);

	localparam int unsigned LW = (AW + 1 > swbt_pkg::CFG_W) ? AW + 1 : swbt_pkg::CFG_W;

	logic [AW-1:0]                ptr_q;
	logic [swbt_pkg::CFG_W-1:0]   fill_q;
	logic [swbt_pkg::CFG_W-1:0]   fill_next;
	logic [LW-1:0]                len_l;
	logic [LW-1:0]                ptr_inc;
	logic [AW-1:0]                ptr_next;

	assign len_l = LW'(len);

	always_comb begin
		ptr = (LW'(ptr_q) >= len_l) ? '0 : ptr_q;
		flags.full_before = (fill_q >= len);
		fill_next = flags.full_before ? fill_q : fill_q + 1'b1;
		flags.full_after = (fill_next >= len);
		ptr_inc = LW'(ptr) + 1'b1;
		ptr_next = (ptr_inc >= len_l) ? '0 : ptr_inc[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (restart) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			ptr_q  <= ptr_next;
			fill_q <= fill_next;
		end
	end

endmodule

/* rtl/core/swbt_count.sv */
// Running set-bit count and threshold state, updated as a request leaves stage 1.
module swbt_count (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          advance,
	input  logic                          bit_s1,
	input  logic                          old_bit_s1,
	input  swbt_pkg::win_flags_t          flags_s1,
	input  logic [swbt_pkg::CFG_W-1:0]    len,
	input  logic [swbt_pkg::CFG_W-1:0]    thr,
	output swbt_pkg::win_state_t          from_state,
	output swbt_pkg::win_state_t          to_state,
	output logic [swbt_pkg::COUNT_W-1:0]  ones
);

	logic [swbt_pkg::COUNT_W-1:0] ones_q;
	swbt_pkg::win_state_t         state_q;
	logic                         drop;
	logic [swbt_pkg::COUNT_W:0]   cnt;

	always_comb begin
		drop = flags_s1.full_before && old_bit_s1 && (ones_q != '0);
		cnt  = {1'b0, ones_q} - {{swbt_pkg::COUNT_W{1'b0}}, drop}
			+ {{swbt_pkg::COUNT_W{1'b0}}, bit_s1};
		ones = (cnt > {1'b0, len}) ? len : cnt[swbt_pkg::COUNT_W-1:0];
		if (!flags_s1.full_after)
			to_state = swbt_pkg::ST_NOT_FILLED;
		else if (ones < thr)
			to_state = swbt_pkg::ST_BELOW;
		else
			to_state = swbt_pkg::ST_ABOVE;
		from_state = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_q  <= '0;
			state_q <= swbt_pkg::ST_NOT_FILLED;
		end else if (restart) begin
			ones_q  <= '0;
			state_q <= swbt_pkg::ST_NOT_FILLED;
		end else if (advance) begin
			ones_q  <= ones;
			state_q <= to_state;
		end
	end

endmodule
